/* rtl/spcl_pkg.sv */
// Shared types and codes for the content-code lookup table.
`default_nettype none

package spcl_pkg;

  // Operation codes carried in the op field
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_ADD    = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_ADDED     = 3'd2;
  localparam logic [2:0] ST_PRESENT   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_LOADED    = 3'd5;

  // Field widths
  localparam int CODE_W   = 32;
  localparam int TYPE_W   = 8;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int ENTRY_W  = CODE_W + TYPE_W;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS_RD,
    S_BS_CMP,
    S_SP_RD,
    S_SP_CMP,
    S_FINISH
  } state_t;

  // Outcome of the shared code comparator
  typedef struct packed {
    logic eq;      // key equals probed code
    logic lt;      // key below probed code
    logic b_zero;  // probed code is zero (empty spill slot)
  } cmp_res_t;

endpackage

`default_nettype wire

/* rtl/spcl_cmp.sv */
// Shared 32-bit code comparator used by every search probe.
`default_nettype none

module spcl_cmp (
  input  wire logic [spcl_pkg::CODE_W-1:0] key,
  input  wire logic [spcl_pkg::CODE_W-1:0] probe,
  output spcl_pkg::cmp_res_t               res
);

  always_comb begin
    res.eq     = (key == probe);
    res.lt     = (key < probe);
    res.b_zero = (probe == '0);
  end

endmodule

`default_nettype wire

/* rtl/sorted_plus_spill_code_lookup.sv */
// Top level of the content-code lookup table: sorted area plus spill area.
//
// The block keeps a table of 32-bit content codes with 8-bit types. The
// sorted area (SORTED_DEPTH entries) is filled by load transfers, one slot
// each, which the user must send in ascending code order (the block does
// not enforce it); cfg_data sets how many leading slots the binary search
// covers (values above SORTED_DEPTH saturate). The spill area (SPILL_DEPTH
// entries) starts empty after reset and is filled by add transfers at its
// first empty slot. A lookup probes the sorted area by binary search, then
// scans the spill area from slot 0 until a match or an empty slot. One item
// is worked at a time and in_tready is high only while the block is idle.
// A load writes its slot and goes straight to the finish state. A lookup or
// add alternates read and compare states for each binary-search probe (at
// most 8 for 128 entries), then for each spill slot examined (at most
// SPILL_DEPTH); a hit in the sorted area skips the spill scan. Each probe
// costs one registered memory read followed by one pass through the shared
// comparator. A finished result sits in the output register, so the next
// item is taken while it waits for out_tready.
// No clearing pass follows reset; the spill area uses one valid bit per slot.
// Write cfg_data only while no item is in flight.
`default_nettype none

module sorted_plus_spill_code_lookup #(
  parameter int SORTED_DEPTH = 128,
  parameter int SPILL_DEPTH  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata, from bit 0 up: op[1:0], key_code[33:2], entry_type[41:34],
  // load_index[48:42], zero fill [55:49]
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [spcl_pkg::IN_DATA_W-1:0]    in_tdata,
  // out_tdata, from bit 0 up: status[2:0], found_type[10:3], in_spill[11],
  // slot_index[18:12], zero fill [23:19]
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [spcl_pkg::OUT_DATA_W-1:0]        out_tdata,
  // sorted_count register write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [spcl_pkg::COUNT_W-1:0]      cfg_data
);

  localparam int SA_W  = (SORTED_DEPTH > 1) ? $clog2(SORTED_DEPTH) : 1;
  localparam int CNT_W = $clog2(SORTED_DEPTH + 1);
  localparam int SP_W  = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
  localparam int SPC_W = $clog2(SPILL_DEPTH + 1);

  localparam int CW = spcl_pkg::CODE_W;
  localparam int TW = spcl_pkg::TYPE_W;
  localparam int LW = spcl_pkg::SLOT_W;
  localparam int SW = spcl_pkg::STATUS_W;

  // Unpack the input transfer
  logic [1:0]    in_op;
  logic [CW-1:0] in_key;
  logic [TW-1:0] in_type;
  logic [LW-1:0] in_load_idx;

  assign in_op       = in_tdata[1:0];
  assign in_key      = in_tdata[33:2];
  assign in_type     = in_tdata[41:34];
  assign in_load_idx = in_tdata[48:42];

  // Control and working registers
  spcl_pkg::state_t state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [CW-1:0]    key_r, key_nxt;
  logic [TW-1:0]    typ_r, typ_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [SPC_W-1:0] sp_idx_r, sp_idx_nxt;
  logic [7:0]       sorted_count_r;

  // Result held until the output register is free
  logic [SW-1:0] res_status_r, res_status_nxt;
  logic [TW-1:0] res_type_r, res_type_nxt;
  logic          res_spill_r, res_spill_nxt;
  logic [LW-1:0] res_slot_r, res_slot_nxt;

  // Output register
  logic                            out_valid_r, out_valid_nxt;
  logic [spcl_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_load;

  // Memories: {type, code} per entry, registered read
  logic [spcl_pkg::ENTRY_W-1:0] sorted_mem [SORTED_DEPTH];
  logic [spcl_pkg::ENTRY_W-1:0] spill_mem  [SPILL_DEPTH];
  logic [spcl_pkg::ENTRY_W-1:0] srt_rd_r;
  logic [spcl_pkg::ENTRY_W-1:0] spl_rd_r;
  logic                         spl_rd_vld_r;
  logic [SPILL_DEPTH-1:0]       spill_vld_r;

  logic            srt_we, srt_re, spl_we, spl_re;
  logic [SA_W-1:0] srt_waddr, srt_raddr;
  logic [SP_W-1:0] spl_addr;

  // Shared comparator
  logic [CW-1:0]      cmp_probe;
  spcl_pkg::cmp_res_t cmp_res;

  // Helpers
  logic [CNT_W-1:0] hi_init;
  logic [CNT_W:0]   mid_sum;
  logic [31:0]      mid_ext;
  logic [31:0]      spi_ext;
  logic             is_add;

  assign mid_ext   = 32'(mid_r);
  assign spi_ext   = 32'(sp_idx_r);
  assign spl_addr  = sp_idx_r[SP_W-1:0];
  assign is_add    = (op_r == spcl_pkg::OP_ADD);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign srt_waddr = SA_W'(in_load_idx);

  // Saturate the configured count to the sorted depth
  always_comb begin
    if (32'(sorted_count_r) > 32'(SORTED_DEPTH)) begin
      hi_init = CNT_W'(SORTED_DEPTH);
    end else begin
      hi_init = CNT_W'(sorted_count_r);
    end
  end

  // Empty spill slots (never written since reset) read as code zero
  assign cmp_probe = (state_r == spcl_pkg::S_SP_CMP)
                   ? (spl_rd_vld_r ? spl_rd_r[CW-1:0] : '0)
                   : srt_rd_r[CW-1:0];

  spcl_cmp u_cmp (
    .key   (key_r),
    .probe (cmp_probe),
    .res   (cmp_res)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == spcl_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    typ_nxt        = typ_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    sp_idx_nxt     = sp_idx_r;
    res_status_nxt = res_status_r;
    res_type_nxt   = res_type_r;
    res_spill_nxt  = res_spill_r;
    res_slot_nxt   = res_slot_r;
    srt_we         = 1'b0;
    srt_re         = 1'b0;
    srt_raddr      = mid_r[SA_W-1:0];
    spl_we         = 1'b0;
    spl_re         = 1'b0;
    out_load       = 1'b0;

    case (state_r)
      spcl_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_op;
          key_nxt = in_key;
          typ_nxt = in_type;
          if (in_op == spcl_pkg::OP_LOAD) begin
            // Drop writes beyond the sorted depth, still report loaded
            srt_we         = (32'(in_load_idx) < 32'(SORTED_DEPTH));
            res_status_nxt = spcl_pkg::ST_LOADED;
            res_type_nxt   = '0;
            res_spill_nxt  = 1'b0;
            res_slot_nxt   = in_load_idx;
            state_nxt      = spcl_pkg::S_FINISH;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = hi_init;
            state_nxt = spcl_pkg::S_BS_RD;
          end
        end
      end

      spcl_pkg::S_BS_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CNT_W:1];
          srt_re    = 1'b1;
          srt_raddr = mid_nxt[SA_W-1:0];
          state_nxt = spcl_pkg::S_BS_CMP;
        end else begin
          sp_idx_nxt = '0;
          state_nxt  = spcl_pkg::S_SP_RD;
        end
      end

      spcl_pkg::S_BS_CMP: begin
        if (cmp_res.eq) begin
          res_status_nxt = is_add ? spcl_pkg::ST_PRESENT : spcl_pkg::ST_FOUND;
          res_type_nxt   = srt_rd_r[spcl_pkg::ENTRY_W-1:CW];
          res_spill_nxt  = 1'b0;
          res_slot_nxt   = mid_ext[LW-1:0];
          state_nxt      = spcl_pkg::S_FINISH;
        end else begin
          if (cmp_res.lt) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = CNT_W'(mid_r + 1'b1);
          end
          state_nxt = spcl_pkg::S_BS_RD;
        end
      end

      spcl_pkg::S_SP_RD: begin
        if (sp_idx_r == SPC_W'(SPILL_DEPTH)) begin
          // Spill area scanned to the end without a match or a free slot
          res_status_nxt = is_add ? spcl_pkg::ST_FULL : spcl_pkg::ST_NOT_FOUND;
          res_type_nxt   = '0;
          res_spill_nxt  = 1'b0;
          res_slot_nxt   = '0;
          state_nxt      = spcl_pkg::S_FINISH;
        end else begin
          spl_re    = 1'b1;
          state_nxt = spcl_pkg::S_SP_CMP;
        end
      end

      spcl_pkg::S_SP_CMP: begin
        if (cmp_res.b_zero) begin
          // First empty slot ends the scan
          if (is_add) begin
            spl_we         = 1'b1;
            res_status_nxt = spcl_pkg::ST_ADDED;
            res_type_nxt   = typ_r;
            res_spill_nxt  = 1'b1;
            res_slot_nxt   = spi_ext[LW-1:0];
          end else begin
            res_status_nxt = spcl_pkg::ST_NOT_FOUND;
            res_type_nxt   = '0;
            res_spill_nxt  = 1'b0;
            res_slot_nxt   = '0;
          end
          state_nxt = spcl_pkg::S_FINISH;
        end else if (cmp_res.eq) begin
          res_status_nxt = is_add ? spcl_pkg::ST_PRESENT : spcl_pkg::ST_FOUND;
          res_type_nxt   = spl_rd_r[spcl_pkg::ENTRY_W-1:CW];
          res_spill_nxt  = 1'b1;
          res_slot_nxt   = spi_ext[LW-1:0];
          state_nxt      = spcl_pkg::S_FINISH;
        end else begin
          sp_idx_nxt = SPC_W'(sp_idx_r + 1'b1);
          state_nxt  = spcl_pkg::S_SP_RD;
        end
      end

      spcl_pkg::S_FINISH: begin
        // Hold the result until the output register can take it
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = spcl_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = spcl_pkg::S_IDLE;
      end
    endcase
  end

  // Output register: load a new result, drop the old one once transferred
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'b0, res_slot_r, res_spill_r, res_type_r, res_status_r};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= spcl_pkg::S_IDLE;
      out_valid_r    <= 1'b0;
      sorted_count_r <= '0;
      spill_vld_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        sorted_count_r <= cfg_data;
      end
      if (spl_we) begin
        spill_vld_r[spl_addr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    typ_r        <= typ_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    sp_idx_r     <= sp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_type_r   <= res_type_nxt;
    res_spill_r  <= res_spill_nxt;
    res_slot_r   <= res_slot_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Sorted area memory
  always_ff @(posedge clk) begin
    if (srt_we) begin
      sorted_mem[srt_waddr] <= {in_type, in_key};
    end
    if (srt_re) begin
      srt_rd_r <= sorted_mem[srt_raddr];
    end
  end

  // Spill area memory
  always_ff @(posedge clk) begin
    if (spl_we) begin
      spill_mem[spl_addr] <= {typ_r, key_r};
    end
    if (spl_re) begin
      spl_rd_r     <= spill_mem[spl_addr];
      spl_rd_vld_r <= spill_vld_r[spl_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/spcl_checker.sv */
// Port-level checker for the content-code lookup table, bound to the top level.
`default_nettype none

module spcl_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [spcl_pkg::OUT_DATA_W-1:0]   out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // One item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // Status is one of the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= spcl_pkg::ST_LOADED)
    else $error("status out of range");

  // Misses and full report no type and no slot
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == spcl_pkg::ST_NOT_FOUND ||
                   out_tdata[2:0] == spcl_pkg::ST_FULL)
    |-> out_tdata[18:3] == '0)
    else $error("miss result carries type or slot");

  // Loads report the sorted area and no type
  a_load_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == spcl_pkg::ST_LOADED
    |-> out_tdata[11:3] == '0)
    else $error("load result carries type or spill flag");

endmodule

bind sorted_plus_spill_code_lookup spcl_checker u_spcl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
